// File: src/tbp_pkg.sv
// Package: shared constants, counter type and training function for the tournament predictor.
package tbp_pkg;

  localparam int TABLE_ENTRIES_DEF = 2048;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int HIST_BITS         = 11;
  localparam int CTR_BITS          = 2;

  typedef logic [CTR_BITS-1:0] ctr_t;

  localparam ctr_t CTR_MAX              = 2'd3;
  localparam ctr_t CTR_MIN              = 2'd0;
  localparam ctr_t DIR_RESET            = 2'd3;  // strongly taken
  localparam ctr_t CHOOSE_RESET         = 2'd0;  // strongly prefer gshare

  // 2-bit saturating counter step toward up (1) or down (0)
  function automatic ctr_t ctr_train(input ctr_t c, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: src/tournament_branch_predictor.sv
// Tournament branch predictor (gshare + bimodal with per-address chooser), top level.
// Pipeline: operands are registered, index reduction takes two stages, table read one,
//   then predict/train into the output register. Throughput: one item per cycle unless
//   out_ready is low or clearing runs; the single write port per table sets this figure.
// Reset: history and count clear at once; then a clearing pass writes the counter tables
//   to their reset values while in_ready stays low.
module tournament_branch_predictor #(
  parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = tbp_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        predicted_taken,
  output logic        used_gshare,
  output logic        prediction_correct,
  output logic [31:0] correct_count
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int RED_W = IDX_W + 1;  // partial remainder, below 2*TABLE_ENTRIES

  // Reciprocal for index = x mod TABLE_ENTRIES:
  // q0 = (x * RECIP) >> 32 is the true quotient or one less, so x - q0*N < 2N
  // and a single compare/subtract finishes the remainder.
  localparam logic [32:0] ONE_32 = 33'h1_0000_0000;
  localparam logic [31:0] RECIP  = 32'(ONE_32 / 33'(TABLE_ENTRIES));
  localparam logic [31:0] NDIV   = 32'(TABLE_ENTRIES);
  localparam logic [RED_W-1:0] NRED = RED_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Pipeline handshake: every stage moves when the one after it has room.
  // ---------------------------------------------------------------------------
  logic v0, v1, v2, v3;
  logic adv0, adv1, adv2, adv3;
  logic clearing;
  logic in_fire;

  assign adv3     = v3 && (!out_valid || out_ready);
  assign adv2     = v2 && (!v3 || adv3);
  assign adv1     = v1 && (!v2 || adv2);
  assign adv0     = v0 && (!v1 || adv1);
  assign in_ready = !clearing && (!v0 || adv0);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire)   v0 <= 1'b1;
      else if (adv0) v0 <= 1'b0;
      if (adv0)      v1 <= 1'b1;
      else if (adv1) v1 <= 1'b0;
      if (adv1)      v2 <= 1'b1;
      else if (adv2) v2 <= 1'b0;
      if (adv2)      v3 <= 1'b1;
      else if (adv3) v3 <= 1'b0;
      if (adv3)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Global history: the outcome is known at accept, so the history moves here
  // and every item sees exactly the outcomes of the items before it.
  // ---------------------------------------------------------------------------
  logic [tbp_pkg::HIST_BITS-1:0] history;

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (in_fire) begin
      history <= {history[tbp_pkg::HIST_BITS-2:0], taken};
    end
  end

  // Stage 0: raw index operands
  logic [31:0] s0_xl, s0_xg;
  logic        s0_taken;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_xl    <= branch_address;
      s0_xg    <= branch_address ^ 32'(history);
      s0_taken <= taken;
    end
  end

  // Stage 1: estimated quotients
  logic [63:0] prod_l, prod_g;
  logic [31:0] s1_xl, s1_xg, s1_ql, s1_qg;
  logic        s1_taken;

  assign prod_l = s0_xl * RECIP;
  assign prod_g = s0_xg * RECIP;

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_xl    <= s0_xl;
      s1_xg    <= s0_xg;
      s1_ql    <= prod_l[63:32];
      s1_qg    <= prod_g[63:32];
      s1_taken <= s0_taken;
    end
  end

  // Stage 2: partial remainders (below 2N)
  logic [31:0] rem_l, rem_g;
  logic [RED_W-1:0] s2_rl, s2_rg;
  logic             s2_taken;

  assign rem_l = s1_xl - 32'(s1_ql * NDIV);
  assign rem_g = s1_xg - 32'(s1_qg * NDIV);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_rl    <= rem_l[RED_W-1:0];
      s2_rg    <= rem_g[RED_W-1:0];
      s2_taken <= s1_taken;
    end
  end

  // Final correction gives the table indexes used for the read
  logic [RED_W-1:0] rl_fix, rg_fix;
  logic [IDX_W-1:0] rd_li, rd_gi;

  assign rl_fix = (s2_rl >= NRED) ? (s2_rl - NRED) : s2_rl;
  assign rg_fix = (s2_rg >= NRED) ? (s2_rg - NRED) : s2_rg;
  assign rd_li  = rl_fix[IDX_W-1:0];
  assign rd_gi  = rg_fix[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Counter tables, one read and one write port each.
  // ---------------------------------------------------------------------------
  tbp_pkg::ctr_t gmem [TABLE_ENTRIES];
  tbp_pkg::ctr_t lmem [TABLE_ENTRIES];
  tbp_pkg::ctr_t cmem [TABLE_ENTRIES];

  tbp_pkg::ctr_t g_rd, l_rd, c_rd;
  logic [IDX_W-1:0] s3_li, s3_gi;
  logic             s3_taken;

  logic             we;
  logic [IDX_W-1:0] w_li, w_gi;
  tbp_pkg::ctr_t    w_g, w_l, w_c;

  always_ff @(posedge clk) begin
    if (adv2) g_rd <= gmem[rd_gi];
    if (we)   gmem[w_gi] <= w_g;
  end

  always_ff @(posedge clk) begin
    if (adv2) l_rd <= lmem[rd_li];
    if (we)   lmem[w_li] <= w_l;
  end

  always_ff @(posedge clk) begin
    if (adv2) c_rd <= cmem[rd_li];
    if (we)   cmem[w_li] <= w_c;
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_li    <= rd_li;
      s3_gi    <= rd_gi;
      s3_taken <= s2_taken;
    end
  end

  // Clearing pass after reset
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_IDX) clearing <= 1'b0;
      else                     clr_idx  <= clr_idx + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: predict and train.
  // The write from the item just ahead lands on the same edge as this item's
  // read, so the most recent write is kept and forwarded on an index match.
  // ---------------------------------------------------------------------------
  logic             byp_valid;
  logic [IDX_W-1:0] byp_li, byp_gi;
  tbp_pkg::ctr_t    byp_g, byp_l, byp_c;

  tbp_pkg::ctr_t g_cur, l_cur, c_cur;
  tbp_pkg::ctr_t g_new, l_new, c_new;
  logic g_pred, b_pred, use_g, pred, g_ok, b_ok, correct;

  logic [COUNT_BITS-1:0] hit_total, hit_total_next;

  always_comb begin
    g_cur = (byp_valid && byp_gi == s3_gi) ? byp_g : g_rd;
    l_cur = (byp_valid && byp_li == s3_li) ? byp_l : l_rd;
    c_cur = (byp_valid && byp_li == s3_li) ? byp_c : c_rd;

    g_pred  = g_cur[1];   // 2 or 3 predicts taken
    b_pred  = l_cur[1];
    use_g   = !c_cur[1];  // 0 or 1 picks gshare
    pred    = use_g ? g_pred : b_pred;
    correct = (pred == s3_taken);
    g_ok    = (g_pred == s3_taken);
    b_ok    = (b_pred == s3_taken);

    // chooser moves only when exactly one component was right
    priority if (g_ok && !b_ok) c_new = tbp_pkg::ctr_train(c_cur, 1'b0);
    else if (b_ok && !g_ok)     c_new = tbp_pkg::ctr_train(c_cur, 1'b1);
    else                        c_new = c_cur;

    g_new = tbp_pkg::ctr_train(g_cur, s3_taken);
    l_new = tbp_pkg::ctr_train(l_cur, s3_taken);

    hit_total_next = hit_total;
    if (correct && hit_total != '1) hit_total_next = hit_total + 1'b1;
  end

  // Shared write port: clearing pass or training writes
  always_comb begin
    we = clearing || adv3;
    if (clearing) begin
      w_li = clr_idx;
      w_gi = clr_idx;
      w_g  = tbp_pkg::DIR_RESET;
      w_l  = tbp_pkg::DIR_RESET;
      w_c  = tbp_pkg::CHOOSE_RESET;
    end else begin
      w_li = s3_li;
      w_gi = s3_gi;
      w_g  = g_new;
      w_l  = l_new;
      w_c  = c_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
      hit_total <= '0;
    end else if (adv3) begin
      byp_valid <= 1'b1;
      hit_total <= hit_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      byp_li <= s3_li;
      byp_gi <= s3_gi;
      byp_g  <= g_new;
      byp_l  <= l_new;
      byp_c  <= c_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv3) begin
      predicted_taken    <= pred;
      used_gshare        <= use_g;
      prediction_correct <= correct;
      correct_count      <= 32'(hit_total_next);
    end
  end

endmodule
